FILE: rtl/drr_pkg.sv
// drr_pkg: shared types and constants for the dependency-aware rule reorder block
// no dependencies
`timescale 1ns / 1ps

package drr_pkg;

   localparam int ID_W  = 3;
   localparam int POS_W = 3;
   localparam int DEP_W = 64;
   localparam int SEL_W = 2 * ID_W;

   // pairs (5,4), (4,3) and (3,2) set out of reset
   localparam logic [DEP_W-1:0] DEP_RESET = 64'd17626612891648;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MOVE,
      ST_WALK
   } state_type;

   typedef struct packed {
      logic            en;
      logic [ID_W-1:0] data;
   } rf_wr_type;

endpackage

FILE: rtl/drr_rule_file.sv
// drr_rule_file: rule order registers, one read port and one write port
// depends on drr_pkg
`timescale 1ns / 1ps

module drr_rule_file import drr_pkg::*; #(
   parameter int NUM_RULES = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [$clog2(NUM_RULES)-1:0] rd_addr,
   output logic [ID_W-1:0]              rd_data,
   input  logic [$clog2(NUM_RULES)-1:0] wr_addr,
   input  rf_wr_type                    wr
);

   logic [ID_W-1:0] order_ff [NUM_RULES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_RULES; i++) begin
            order_ff[i] <= ID_W'(i);
         end
      end else if (wr.en) begin
         order_ff[wr_addr] <= wr.data;
      end
   end

   assign rd_data = order_ff[rd_addr];

endmodule

FILE: rtl/drr_dep_unit.sv
// drr_dep_unit: dependency matrix register and the shared pass check
// depends on drr_pkg
`timescale 1ns / 1ps

module drr_dep_unit import drr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [DEP_W-1:0] csr_wr_data,
   input  logic [ID_W-1:0]  mover,
   input  logic [ID_W-1:0]  ahead,
   output logic             blocked
);

   logic [DEP_W-1:0] matrix_ff;
   logic [SEL_W-1:0] sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= DEP_RESET;
      end else if (csr_wr_en) begin
         matrix_ff <= csr_wr_data;
      end
   end

   assign sel     = {mover, ahead};
   assign blocked = matrix_ff[sel];

endmodule

FILE: rtl/drr_seq.sv
// drr_seq: sequencer for search, move-forward and walk-back steps
// depends on drr_pkg
`timescale 1ns / 1ps

module drr_seq import drr_pkg::*; #(
   parameter int NUM_RULES = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ID_W-1:0]              req_packet_id,
   output logic [$clog2(NUM_RULES)-1:0] rd_addr,
   input  logic [ID_W-1:0]              rd_data,
   output logic [$clog2(NUM_RULES)-1:0] wr_addr,
   output rf_wr_type                    wr,
   output logic [ID_W-1:0]              mover,
   input  logic                         blocked,
   output logic                         rsp_valid,
   output logic                         rsp_hit,
   output logic [POS_W-1:0]             rsp_position
);

   localparam int IdxW = $clog2(NUM_RULES);
   localparam logic [IdxW-1:0] LAST = IdxW'(NUM_RULES - 1);

   state_type       state_ff, state_in;
   logic [IdxW-1:0] cur_ff, cur_in;
   logic [IdxW-1:0] found_ff, found_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic [ID_W-1:0] carry_ff, carry_in;
   logic            hit_ff, hit_in;
   logic            valid_ff, valid_in;
   logic            at_head;
   logic            match;

   assign at_head = (cur_ff == '0);
   assign match   = (rd_data == id_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (match) state_in = ST_MOVE;
            else if (cur_ff == LAST) state_in = ST_IDLE;
         end
         ST_MOVE: begin
            if (at_head) state_in = ST_IDLE;
            else if (blocked) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (at_head) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cur_in   = cur_ff;
      found_in = found_ff;
      id_in    = id_ff;
      carry_in = carry_ff;
      hit_in   = hit_ff;
      valid_in = 1'b0;
      wr.en    = 1'b0;
      wr.data  = carry_ff;
      rd_addr  = cur_ff - IdxW'(1);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               id_in  = req_packet_id;
               cur_in = '0;
            end
         end
         ST_SEARCH: begin
            rd_addr = cur_ff;
            if (match) begin
               carry_in = rd_data;
            end else if (cur_ff == LAST) begin
               valid_in = 1'b1;
               hit_in   = 1'b0;
               found_in = '0;
            end else begin
               cur_in = cur_ff + IdxW'(1);
            end
         end
         ST_MOVE, ST_WALK: begin
            wr.en = 1'b1;
            if (at_head) begin
               valid_in = 1'b1;
               hit_in   = 1'b1;
               if (state_ff == ST_MOVE) found_in = '0;
            end else begin
               // swap unless the carried entry may not pass its predecessor
               wr.data  = blocked ? carry_ff : rd_data;
               carry_in = blocked ? rd_data : carry_ff;
               cur_in   = cur_ff - IdxW'(1);
               if (state_ff == ST_MOVE && blocked) found_in = cur_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      found_ff <= found_in;
      id_ff    <= id_in;
      carry_ff <= carry_in;
      hit_ff   <= hit_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign wr_addr      = cur_ff;
   assign mover        = carry_ff;
   assign rsp_valid    = valid_ff;
   assign rsp_hit      = hit_ff;
   assign rsp_position = POS_W'(found_ff);

endmodule

FILE: rtl/dependency_aware_rule_reorder.sv
// dependency_aware_rule_reorder: top level of the self-organising rule list
// depends on drr_pkg, drr_rule_file, drr_dep_unit, drr_seq
`timescale 1ns / 1ps

// A packet id is taken when start is high and busy is low. The list is searched
// from the head, one entry a cycle, then the matched rule is moved toward the
// head and the rest of the list walked back to the head, one compare-and-swap a
// cycle through the single dependency check. The result is shown for one cycle
// on rsp_valid right after busy drops and must be taken then; the next transfer
// may start in that same cycle.

module dependency_aware_rule_reorder import drr_pkg::*; #(
   parameter int NUM_RULES = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [ID_W-1:0]  req_packet_id,
   output logic             rsp_valid,
   output logic             rsp_hit,
   output logic [POS_W-1:0] rsp_position,
   input  logic             csr_wr_en,
   input  logic [DEP_W-1:0] csr_wr_data
);

   localparam int IdxW = $clog2(NUM_RULES);

   logic [IdxW-1:0] rd_addr;
   logic [IdxW-1:0] wr_addr;
   logic [ID_W-1:0] rd_data;
   logic [ID_W-1:0] mover;
   logic            blocked;
   rf_wr_type       wr;

   drr_rule_file #(.NUM_RULES(NUM_RULES)) u_rule_file (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_addr (wr_addr),
      .wr      (wr)
   );

   drr_dep_unit u_dep_unit (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mover       (mover),
      .ahead       (rd_data),
      .blocked     (blocked)
   );

   drr_seq #(.NUM_RULES(NUM_RULES)) u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_packet_id (req_packet_id),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .wr_addr       (wr_addr),
      .wr            (wr),
      .mover         (mover),
      .blocked       (blocked),
      .rsp_valid     (rsp_valid),
      .rsp_hit       (rsp_hit),
      .rsp_position  (rsp_position)
   );

endmodule

FILE: rtl/drr_checker.sv
// drr_checker: port-level assertions for dependency_aware_rule_reorder
// depends on drr_pkg; bound to the top level below
`timescale 1ns / 1ps

module drr_checker import drr_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input logic             rsp_hit,
   input logic [POS_W-1:0] rsp_position
);

   // a taken transfer makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after transfer");

   // result only shows once the work is done
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   // result strobe lasts one cycle
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a miss reports the head position
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_position == '0)
      else $error("miss with non-zero position");

   // every end of work gives a result
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("work ended without result");

endmodule

bind dependency_aware_rule_reorder drr_checker u_drr_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_hit      (rsp_hit),
   .rsp_position (rsp_position)
);
